### rtl/core/fraction_reduce_and_sort_core_assert.svh
// -----------------------------------------------------------------------------
// fraction_reduce_and_sort_core_assert
// Assertion macros for the fraction reduce and sort core.
// -----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_AND_SORT_CORE_ASSERT_SVH
`define FRACTION_REDUCE_AND_SORT_CORE_ASSERT_SVH

// Assert a property on the rising clock, disabled during reset.
`define FRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that one condition implies another in the next cycle.
`define FRS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/frs_pkg.sv
// -----------------------------------------------------------------------------
// frs_pkg
// Shared command and status types for the fraction reduce and sort core.
// -----------------------------------------------------------------------------
package frs_pkg;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture the input item
    CMD_GCD_INIT,  // load gcd operands from magnitudes
    CMD_DIV_INIT,  // start divide of magnitudes by gcd
    CMD_DIV_STEP,  // one restoring divide step on both quotients
    CMD_STORE,     // write reduced fraction into the store
    CMD_RD_PAIR,   // read entries i and j
    CMD_MUL,       // form cross products
    CMD_SWAP_A,    // write entry j into slot i
    CMD_SWAP_B,    // write entry i into slot j
    CMD_RD_OUT,    // read entry i for output
    CMD_EMIT       // load output register
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic gcd_step;
  } frs_ctrl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic skip;     // zero numerator, no reduction
    logic drop;     // zero denominator or full store
    logic less;     // entry i below entry j
    logic out_busy; // output register holds an item
  } frs_stat_t;

endpackage

### rtl/core/frs_datapath.sv
// -----------------------------------------------------------------------------
// frs_datapath
// Store, gcd subtract unit, bit-serial divider, cross multiply and output.
// -----------------------------------------------------------------------------
module frs_datapath #(
  parameter int MaxFractions = 16,
  parameter int ValueWidth   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  frs_pkg::frs_ctrl_t           ctrl_i,
  input  logic [$clog2(MaxFractions)-1:0] idx_i,
  input  logic [$clog2(MaxFractions)-1:0] idx_j_i,
  input  logic [$clog2(MaxFractions+1)-1:0] count_i,
  input  logic                         last_flag_i,
  input  logic signed [ValueWidth-1:0] numerator_i,
  input  logic signed [ValueWidth-1:0] denominator_i,
  output frs_pkg::frs_stat_t           stat_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [ValueWidth-1:0] out_numerator_o,
  output logic [ValueWidth-1:0]        out_denominator_o,
  output logic                         last_result_o
);
  localparam int IW = $clog2(MaxFractions);
  localparam int KW = $clog2(MaxFractions + 1);
  localparam int MW = ValueWidth + 1;
  localparam int CW = $clog2(ValueWidth + 2);
  localparam int PW = 2 * MW;
  localparam logic [MW-1:0] PosMax = MW'((1 << (ValueWidth - 1)) - 1);

  logic signed [ValueWidth-1:0] num_store [MaxFractions];
  logic [MW-1:0]                den_store [MaxFractions];

  logic sn_q, sd_q;
  logic [MW-1:0] ma_q, mb_q, ga_q, gb_q;
  logic [MW-1:0] qn_q, qd_q, rn_q, rd_q;
  logic [CW-1:0] bit_q;
  logic signed [ValueWidth-1:0] ni_q, nj_q;
  logic [MW-1:0] di_q, dj_q;
  logic signed [PW:0] pl_q, pr_q;
  logic ov_q;
  logic signed [ValueWidth-1:0] on_q;
  logic [ValueWidth-1:0] od_q;
  logic ol_q;

  logic [MW-1:0] rn_sh, rd_sh;
  logic [MW:0] fn, fd, sum_num;
  logic [MW-1:0] mag_n, mag_d;
  logic neg;
  logic signed [MW:0] snum;
  logic [MW-1:0] res_n, res_d;

  always_comb begin
    mag_n = numerator_i[ValueWidth-1] ? MW'(-{numerator_i[ValueWidth-1], numerator_i})
                                      : MW'({1'b0, numerator_i});
    mag_d = denominator_i[ValueWidth-1]
          ? MW'(-{denominator_i[ValueWidth-1], denominator_i})
          : MW'({1'b0, denominator_i});
    rn_sh = {rn_q[MW-2:0], qn_q[MW-1]};
    rd_sh = {rd_q[MW-2:0], qd_q[MW-1]};
    fn = {1'b0, rn_sh} - {1'b0, ga_q};
    fd = {1'b0, rd_sh} - {1'b0, ga_q};
    neg = sn_q ^ sd_q;
    res_n = (ma_q == '0) ? ma_q : qn_q;
    res_d = (ma_q == '0) ? mb_q : qd_q;
    sum_num = neg ? {1'b1, -res_n} : {1'b0, res_n};
    snum = $signed(sum_num);
    stat_o.gcd_done = (gb_q == '0);
    stat_o.div_done = (bit_q == '0);
    stat_o.skip     = (ma_q == '0);
    stat_o.drop     = (mb_q == '0) || (count_i == KW'(MaxFractions));
    stat_o.less     = pl_q < pr_q;
    stat_o.out_busy = ov_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      frs_pkg::CMD_LOAD: begin
        sn_q <= numerator_i[ValueWidth-1];
        sd_q <= denominator_i[ValueWidth-1];
        ma_q <= mag_n;
        mb_q <= mag_d;
      end
      frs_pkg::CMD_GCD_INIT: begin
        ga_q <= ma_q;
        gb_q <= mb_q;
      end
      frs_pkg::CMD_DIV_INIT: begin
        qn_q <= ma_q;
        qd_q <= mb_q;
        rn_q <= '0;
        rd_q <= '0;
        bit_q <= CW'(MW);
      end
      frs_pkg::CMD_DIV_STEP: begin
        bit_q <= bit_q - 1'b1;
        rn_q <= fn[MW] ? rn_sh : fn[MW-1:0];
        rd_q <= fd[MW] ? rd_sh : fd[MW-1:0];
        qn_q <= {qn_q[MW-2:0], ~fn[MW]};
        qd_q <= {qd_q[MW-2:0], ~fd[MW]};
      end
      frs_pkg::CMD_STORE: begin
        num_store[count_i[IW-1:0]] <=
          (!snum[MW] && snum[MW-1:0] > PosMax) ? ValueWidth'(PosMax)
                                                 : snum[ValueWidth-1:0];
        den_store[count_i[IW-1:0]] <= res_d;
      end
      frs_pkg::CMD_RD_PAIR: begin
        ni_q <= num_store[idx_i];
        di_q <= den_store[idx_i];
        nj_q <= num_store[idx_j_i];
        dj_q <= den_store[idx_j_i];
      end
      frs_pkg::CMD_MUL: begin
        pl_q <= (PW+1)'(ni_q * $signed({1'b0, dj_q}));
        pr_q <= (PW+1)'($signed({1'b0, di_q}) * nj_q);
      end
      frs_pkg::CMD_SWAP_A: begin
        num_store[idx_i] <= nj_q;
        den_store[idx_i] <= dj_q;
      end
      frs_pkg::CMD_SWAP_B: begin
        num_store[idx_j_i] <= ni_q;
        den_store[idx_j_i] <= di_q;
      end
      frs_pkg::CMD_RD_OUT: begin
        ni_q <= num_store[idx_i];
        di_q <= den_store[idx_i];
      end
      frs_pkg::CMD_EMIT: begin
        on_q <= ni_q;
        od_q <= di_q[ValueWidth-1:0];
        ol_q <= last_flag_i;
      end
      default: ;
    endcase
    if (ctrl_i.gcd_step) begin
      // subtractive gcd: hold the larger minus the smaller
      if (ga_q >= gb_q) begin
        ga_q <= gb_q;
        gb_q <= ga_q - gb_q;
      end else begin
        gb_q <= gb_q - ga_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctrl_i.cmd == frs_pkg::CMD_EMIT) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o       = ov_q;
  assign out_numerator_o   = on_q;
  assign out_denominator_o = od_q;
  assign last_result_o     = ol_q;
endmodule

### rtl/core/frs_ctrl.sv
// -----------------------------------------------------------------------------
// frs_ctrl
// Sequencer: reduce each item; on a last item, exchange sort and emit the set.
// -----------------------------------------------------------------------------
module frs_ctrl #(
  parameter int MaxFractions = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           last_item_i,
  input  frs_pkg::frs_stat_t             stat_i,
  output frs_pkg::frs_ctrl_t             ctrl_o,
  output logic [$clog2(MaxFractions)-1:0] idx_i_o,
  output logic [$clog2(MaxFractions)-1:0] idx_j_o,
  output logic [$clog2(MaxFractions+1)-1:0] count_o,
  output logic                           last_flag_o
);
  localparam int IW = $clog2(MaxFractions);
  localparam int CW = $clog2(MaxFractions + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_GCD, S_DIVI, S_DIV, S_STORE, S_SORT_RD, S_SORT_MUL,
    S_SORT_CMP, S_SWAP_B, S_OUT_RD, S_OUT
  } state_e;

  state_e state_q;
  logic last_q;
  logic [CW-1:0] count_q, i_q, j_q;
  logic accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign idx_i_o    = i_q[IW-1:0];
  assign idx_j_o    = j_q[IW-1:0];
  assign count_o    = count_q;
  assign last_flag_o = (i_q + 1'b1 == count_q);

  always_comb begin
    ctrl_o.cmd = frs_pkg::CMD_NONE;
    ctrl_o.gcd_step = 1'b0;
    unique case (state_q)
      S_IDLE:     if (accept) ctrl_o.cmd = frs_pkg::CMD_LOAD;
      S_CHECK:    ctrl_o.cmd = frs_pkg::CMD_GCD_INIT;
      S_GCD:      ctrl_o.gcd_step = !stat_i.gcd_done;
      S_DIVI:     ctrl_o.cmd = frs_pkg::CMD_DIV_INIT;
      S_DIV:      if (!stat_i.div_done) ctrl_o.cmd = frs_pkg::CMD_DIV_STEP;
      S_STORE:    ctrl_o.cmd = frs_pkg::CMD_STORE;
      S_SORT_RD:  ctrl_o.cmd = frs_pkg::CMD_RD_PAIR;
      S_SORT_MUL: ctrl_o.cmd = frs_pkg::CMD_MUL;
      S_SORT_CMP: if (stat_i.less) ctrl_o.cmd = frs_pkg::CMD_SWAP_A;
      S_SWAP_B:   ctrl_o.cmd = frs_pkg::CMD_SWAP_B;
      S_OUT_RD:   ctrl_o.cmd = frs_pkg::CMD_RD_OUT;
      S_OUT:      if (!stat_i.out_busy) ctrl_o.cmd = frs_pkg::CMD_EMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q  <= last_item_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          i_q <= '0;
          j_q <= CW'(1);
          if (stat_i.drop) begin
            state_q <= last_q ? S_SORT_RD : S_IDLE;
          end else begin
            state_q <= stat_i.skip ? S_STORE : S_GCD;
          end
        end
        S_GCD:  if (stat_i.gcd_done) state_q <= S_DIVI;
        S_DIVI: state_q <= S_DIV;
        S_DIV:  if (stat_i.div_done) state_q <= S_STORE;
        S_STORE: begin
          count_q <= count_q + 1'b1;
          i_q     <= '0;
          j_q     <= CW'(1);
          state_q <= last_q ? S_SORT_RD : S_IDLE;
        end
        S_SORT_RD: begin
          // end the sort when fewer than two entries remain from i onward
          if (j_q >= count_q) begin
            i_q <= '0;
            state_q <= (count_q == '0) ? S_IDLE : S_OUT_RD;
          end else begin
            state_q <= S_SORT_MUL;
          end
        end
        S_SORT_MUL: state_q <= S_SORT_CMP;
        S_SORT_CMP, S_SWAP_B: begin
          if (state_q == S_SORT_CMP && stat_i.less) begin
            state_q <= S_SWAP_B;
          end else begin
            if (j_q + 1'b1 >= count_q) begin
              i_q <= i_q + 1'b1;
              j_q <= i_q + 2'd2;
            end else begin
              j_q <= j_q + 1'b1;
            end
            state_q <= S_SORT_RD;
          end
        end
        S_OUT_RD: state_q <= S_OUT;
        S_OUT: begin
          if (!stat_i.out_busy) begin
            if (last_flag_o) begin
              count_q <= '0;
              state_q <= S_IDLE;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= S_OUT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/fraction_reduce_and_sort_core.sv
// -----------------------------------------------------------------------------
// fraction_reduce_and_sort_core
// Reduces signed fractions to lowest terms and emits each set sorted.
// -----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with numerator_i, denominator_i and
// last_item_i. An item is taken when valid is high and stall is low. Stall is
// high while an item is reduced or a set is sorted and emitted.
// A kept item with a nonzero numerator holds the input from acceptance through
// load and check, the subtract steps of the gcd until it is seen done, the start
// and run of the bit-serial divide, and the store write. The subtractive gcd is
// slow for a large magnitude over a small one, such as 2^(VALUE_WIDTH-1) over
// one. A zero numerator skips the reduction and goes from the check straight to
// the store write; a zero denominator or a full store drops the item at the check.
// On a last item the exchange sort walks all pairs: it reads the pair, forms both
// cross products, compares them and swaps when entry i is below entry j, then
// reads out and emits each entry in turn while the receiver takes them.
// Output channel: out_valid_o / out_stall_i; an output register holds a
// result until taken, and the sequencer waits while it is full.
// Reset clears the controller, the item count and the output valid; the store holds no reset.
// -----------------------------------------------------------------------------
`include "fraction_reduce_and_sort_core_assert.svh"

module fraction_reduce_and_sort_core #(
  parameter int MAX_FRACTIONS = 16,
  parameter int VALUE_WIDTH   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] numerator_i,
  input  logic signed [VALUE_WIDTH-1:0] denominator_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] out_numerator_o,
  output logic [VALUE_WIDTH-1:0]        out_denominator_o,
  output logic                          last_result_o
);
  localparam int IW = $clog2(MAX_FRACTIONS);
  localparam int CW = $clog2(MAX_FRACTIONS + 1);

  frs_pkg::frs_ctrl_t ctrl;
  frs_pkg::frs_stat_t stat;
  logic [IW-1:0] idx_i, idx_j;
  logic [CW-1:0] count;
  logic last_flag;

  // Sequencer: command per cycle, index and count registers.
  frs_ctrl #(.MaxFractions(MAX_FRACTIONS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .last_item_i,
    .stat_i(stat), .ctrl_o(ctrl), .idx_i_o(idx_i), .idx_j_o(idx_j),
    .count_o(count), .last_flag_o(last_flag)
  );

  // Datapath: store, gcd, divider, cross multiply, output register.
  frs_datapath #(.MaxFractions(MAX_FRACTIONS), .ValueWidth(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .idx_i(idx_i), .idx_j_i(idx_j),
    .count_i(count), .last_flag_i(last_flag), .numerator_i, .denominator_i,
    .stat_o(stat), .out_valid_o, .out_stall_i, .out_numerator_o,
    .out_denominator_o, .last_result_o
  );

  // Never load the output register while it still holds an item.
  `FRS_ASSERT(a_no_overwrite, !(ctrl.cmd == frs_pkg::CMD_EMIT && stat.out_busy),
              "output overwritten")
  // Hold a stalled result unchanged until it is taken.
  `FRS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_numerator_o) && $stable(out_denominator_o),
                   "stalled result changed")
  // Check that the item count is nonzero after every store.
  `FRS_ASSERT_NEXT(a_store_count, ctrl.cmd == frs_pkg::CMD_STORE, count != '0,
                   "count not advanced")
endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// Drives sets of signed fractions into the reduce-and-sort core and checks
// each sorted, reduced result against a local model of the block.
// -----------------------------------------------------------------------------
module tb;

  localparam int NMAX = 16;
  localparam int W    = 16;

  typedef struct packed {
    logic signed [W-1:0] num;
    logic [W-1:0]        den;
    logic                last;
  } frac_t;

  typedef struct {
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
    logic                last;
    logic                chk;   // expected result typed in for this row
    frac_t               exp0;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [W-1:0] numerator_i = '0;
  logic signed [W-1:0] denominator_i = '0;
  logic last_item_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [W-1:0] out_numerator_o;
  logic [W-1:0] out_denominator_o;
  logic last_result_o;

  fraction_reduce_and_sort_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reduced fractions waiting for the last item of their set
  longint set_num[$];
  longint set_den[$];
  frac_t sorted_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit hold_long = 0;
  bit random_phase = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic longint gcd_mag(input longint a, input longint b);
    longint r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Reduce one fraction into the set; on a last item sort and queue it.
  task automatic reduce_and_collect(input logic signed [W-1:0] n_in,
                                    input logic signed [W-1:0] d_in,
                                    input logic lst);
    longint n, d, g, tn, td;
    int cnt;
    frac_t r;
    n = n_in;
    d = d_in;
    if (d != 0 && set_num.size() < NMAX) begin
      if (n != 0) begin
        g = gcd_mag(n < 0 ? -n : n, d < 0 ? -d : d);
        n = n / g;
        d = d / g;
      end
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      if (n > 32767) n = 32767;
      set_num.push_back(n);
      set_den.push_back(d);
    end
    if (!lst) return;
    cnt = set_num.size();
    for (int i = 0; i + 1 < cnt; i++)
      for (int j = i + 1; j < cnt; j++)
        if (set_num[i] * set_den[j] < set_den[i] * set_num[j]) begin
          tn = set_num[i]; td = set_den[i];
          set_num[i] = set_num[j]; set_den[i] = set_den[j];
          set_num[j] = tn; set_den[j] = td;
        end
    for (int i = 0; i < cnt; i++) begin
      r.num = set_num[i][W-1:0];
      r.den = set_den[i][W-1:0];
      r.last = (i == cnt - 1);
      sorted_q.push_back(r);
    end
    set_num.delete();
    set_den.delete();
  endtask

  // Offer one item, hold it through stall, advance on acceptance.
  task automatic send(input logic signed [W-1:0] n, input logic signed [W-1:0] d,
                      input logic lst);
    int gap;
    gap = $urandom_range(0, 4);
    if (random_phase && $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    numerator_i <= n;
    denominator_i <= d;
    last_item_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    reduce_and_collect(n, d, lst);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  // Check each taken result against the oldest expectation.
  always @(posedge clk_i) begin
    frac_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d", out_numerator_o, out_denominator_o));
      end else begin
        want = sorted_q.pop_front();
        if (out_numerator_o !== want.num)
          report($sformatf("numerator %0d, want %0d", out_numerator_o, want.num));
        if (out_denominator_o !== want.den)
          report($sformatf("denominator %0d, want %0d", out_denominator_o, want.den));
        if (last_result_o !== want.last)
          report($sformatf("last flag %0b, want %0b", last_result_o, want.last));
      end
    end
  end

  // Receiver: random stall spells, one long hold-off on request.
  initial begin
    int w;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (600) @(negedge clk_i);
        hold_long = 0;
        out_stall_i <= 1'b0;
      end else if (random_phase && $urandom_range(0, 9) < 3) begin
        out_stall_i <= 1'b0;
      end else begin
        w = $urandom_range(0, 4);
        if (w != 0) begin
          out_stall_i <= 1'b1;
          repeat (w) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  row_t dir[$];

  function automatic row_t mk(input int n, input int d, input int l,
                              input int c = 0, input int en = 0, input int ed = 0);
    row_t r;
    r.num = W'(n); r.den = W'(d); r.last = (l != 0); r.chk = (c != 0);
    r.exp0.num = W'(en); r.exp0.den = W'(ed); r.exp0.last = 1'b1;
    return r;
  endfunction

  initial begin
    logic signed [W-1:0] n, d;
    int setlen;
    // Directed table: singletons with obvious results, then a mixed set.
    dir.push_back(mk(0, 5, 1, 1, 0, 5));              // zero numerator kept
    dir.push_back(mk(0, -5, 1, 1, 0, 5));             // sign moved off zero
    dir.push_back(mk(-32768, -1, 1, 1, 32767, 1));    // saturation
    dir.push_back(mk(-32768, -32768, 1, 1, 1, 1));
    dir.push_back(mk(32767, -32768, 1, 1, -32767, 16'h8000));
    dir.push_back(mk(6, -4, 1, 1, -3, 2));
    dir.push_back(mk(7, 0, 1));                       // discarded, empty set
    dir.push_back(mk(-32768, 32767, 0));
    dir.push_back(mk(32767, 1, 0));
    dir.push_back(mk(5, 0, 0));
    dir.push_back(mk(-12, 18, 0));
    dir.push_back(mk(2, -3, 0));
    dir.push_back(mk(0, -32768, 0));
    dir.push_back(mk(21, 14, 1));
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir[k]) begin
      if (dir[k].chk) drain();
      send(dir[k].num, dir[k].den, dir[k].last);
      if (dir[k].chk && sorted_q[0] != dir[k].exp0)
        report($sformatf("row %0d expectation differs from typed value", k));
    end
    // Full store: 18 items, the last two discarded, with a long receiver hold.
    drain();
    for (int k = 0; k < 18; k++) send(W'($urandom), W'($urandom_range(1, 40)), k == 17);
    hold_long = 1;
    for (int k = 0; k < 16; k++) send(W'(k - 8), W'(3), k == 15);
    drain();
    // Random sets, mostly of small size, some noise and zero denominators.
    random_phase = 1;
    while (items_sent < 300) begin
      setlen = $urandom_range(1, 9);
      if ($urandom_range(0, 9) == 0) setlen = $urandom_range(14, 18);
      for (int k = 0; k < setlen; k++) begin
        case ($urandom_range(0, 5))
          0: begin n = W'($urandom); d = W'($urandom); end
          1: begin
            n = W'($urandom_range(0, 30) - 15);
            d = W'($urandom_range(0, 30) - 15);
          end
          2: begin n = 16'sh8000; d = $urandom_range(0, 1) ? -16'sd1 : W'($urandom); end
          default: begin n = W'($urandom % 200 - 100); d = W'($urandom % 60 - 30); end
        endcase
        send(n, d, k == setlen - 1);
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
    $display("Sent %0d items over directed and random sets; checked %0d results.",
             items_sent, results_seen);
    if (errors == 0 && sorted_q.size() == 0 && set_num.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("tb failed");
    $finish;
  end

endmodule
